>>> hw/rtl/stmm_pkg.sv
// stmm_pkg: shared constants and types for the sorted triple merge match core
// no dependencies; used by the channel interfaces and the core module
package stmm_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int OP_W        = 2;
  localparam int MATCH_W     = 13;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } operation_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] x;
    logic signed [KEY_W-1:0] y;
    logic signed [KEY_W-1:0] z;
  } triple_t;

  localparam int TRIPLE_W = $bits(triple_t);

endpackage

>>> hw/rtl/stmm_in_if.sv
// stmm_in_if: input item channel (operation and key triple) with valid/ready
// depends on stmm_pkg
interface stmm_in_if;
  import stmm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] key_x;
  logic signed [KEY_W-1:0] key_y;
  logic signed [KEY_W-1:0] key_z;

  modport source (output valid, operation, key_x, key_y, key_z, input ready);
  modport sink   (input valid, operation, key_x, key_y, key_z, output ready);
endinterface

>>> hw/rtl/stmm_out_if.sv
// stmm_out_if: result item channel (match index and found flag) with valid/ready
// depends on stmm_pkg
interface stmm_out_if;
  import stmm_pkg::*;

  logic               valid;
  logic               ready;
  logic [MATCH_W-1:0] match_index;
  logic               found;

  modport source (output valid, match_index, found, input ready);
  modport sink   (input valid, match_index, found, output ready);
endinterface

>>> hw/rtl/stmm_ram.sv
// stmm_ram: generic single write port, single read port ram with registered read
// no dependencies
module stmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sorted_triple_merge_match_core.sv
// sorted_triple_merge_match_core: sorted merge join of key triples against a table
// clear and load are done without leaving idle; a query reads table entries from the scan
// pointer and advances past each smaller entry; with the pointer at the end it answers unread
// one table ram read per pointer advance; no new item is taken until a query's result is emitted
// reset clears entry count, scan pointer and result valid; table contents stay undefined
// depends on stmm_pkg, stmm_in_if, stmm_out_if, stmm_ram
module sorted_triple_merge_match_core (
  input  logic clk_i,
  input  logic rst_ni,
  stmm_in_if.sink    in_i,
  stmm_out_if.source out_o
);
  import stmm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   ptr_inc;
  triple_t            key_q, key_d;
  logic               out_valid_q, out_valid_d;
  logic [MATCH_W-1:0] out_idx_q, out_idx_d;
  logic               out_found_q, out_found_d;
  logic [MATCH_W-1:0] pend_idx_q, pend_idx_d;
  logic               pend_found_q, pend_found_d;

  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [TRIPLE_W-1:0] ram_rdata;
  triple_t            rd;
  triple_t            in_key;

  logic               accept;
  logic               slot_free;
  logic               lt;
  logic               eq;
  logic               emit;
  logic [MATCH_W-1:0] emit_idx;
  logic               emit_found;
  logic [CNT_W:0]     pos;

  assign in_key    = '{x: in_i.key_x, y: in_i.key_y, z: in_i.key_z};
  assign rd        = triple_t'(ram_rdata);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign ptr_inc   = ptr_q + CNT_W'(1);
  assign pos       = {1'b0, ptr_q} + (CNT_W + 1)'(1);

  assign eq = (rd.x == key_q.x) && (rd.y == key_q.y) && (rd.z == key_q.z);
  assign lt = (rd.x < key_q.x) ||
              ((rd.x == key_q.x) && ((rd.y < key_q.y) ||
                                     ((rd.y == key_q.y) && (rd.z < key_q.z))));

  stmm_ram #(
    .WIDTH (TRIPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (in_key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    key_d        = key_q;
    out_valid_d  = out_valid_q;
    out_idx_d    = out_idx_q;
    out_found_d  = out_found_q;
    pend_idx_d   = pend_idx_q;
    pend_found_d = pend_found_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q[IDX_W-1:0];
    emit         = 1'b0;
    emit_idx     = '0;
    emit_found   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = in_key;
          unique case (in_i.operation)
            OP_CLEAR: begin
              count_d = '0;
              ptr_d   = '0;
            end
            OP_LOAD: begin
              if (count_q < CNT_W'(TABLE_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_QUERY: begin
              if (ptr_q < count_q) begin
                ram_re  = 1'b1;
                state_d = ST_CMP;
              end else begin
                emit = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (lt) begin
          ptr_d = ptr_inc;
          if (ptr_inc < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_inc[IDX_W-1:0];
          end else begin
            emit = 1'b1;
          end
        end else if (eq) begin
          emit       = 1'b1;
          emit_idx   = pos[MATCH_W-1:0];
          emit_found = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      ST_EMIT: begin
        emit       = 1'b1;
        emit_idx   = pend_idx_q;
        emit_found = pend_found_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        out_idx_d   = emit_idx;
        out_found_d = emit_found;
        state_d     = ST_IDLE;
      end else begin
        pend_idx_d   = emit_idx;
        pend_found_d = emit_found;
        state_d      = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    out_idx_q    <= out_idx_d;
    out_found_q  <= out_found_d;
    pend_idx_q   <= pend_idx_d;
    pend_found_q <= pend_found_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.match_index = out_idx_q;
  assign out_o.found       = out_found_q;

endmodule
